>>> src/cge_pkg.sv
// shared types, constants and helpers of the color gradient edge map
package cge_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 24;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int WT_W       = 4;
  localparam int THR_W      = 13;
  localparam int GEOM_W     = 13;
  localparam int ROW_W      = 13;
  localparam int E_W        = 25;
  localparam int M_W        = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_WT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_WT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THR     = 3'd4;

  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 12'd480;
  localparam logic [WT_W-1:0]     RST_DELTA  = 4'd9;
  localparam logic [WT_W-1:0]     RST_CHAN   = 4'd4;
  localparam logic [THR_W-1:0]    RST_THR    = 13'd80;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [WT_W-1:0]     delta_wt;
    logic [WT_W-1:0]     chan_wt;
    logic [THR_W-1:0]    thr;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic zero_pix;
    logic mem_rd;
    logic shift;
    logic pick;
    logic kc2;
    logic hl;
    logic hr;
    logic hu;
    logic hd;
    logic sqrt_start;
    logic load_out;
    logic fend;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic out_free;
  } stat_t;

  // max minus min of the three channels
  function automatic logic [CH_W-1:0] spread8(input logic [PIX_W-1:0] p);
    logic [CH_W-1:0] r, g, b, hi, lo;
    r = p[23:16];
    g = p[15:8];
    b = p[7:0];
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    return hi - lo;
  endfunction

endpackage

>>> src/cge_in_if.sv
// pixel input channel
interface cge_in_if;
  import cge_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            padding;
  modport source(output valid, red, green, blue, padding, input ready);
  modport sink(input valid, red, green, blue, padding, output ready);
endinterface

>>> src/cge_out_if.sv
// gradient result channel
interface cge_out_if;
  import cge_pkg::*;
  logic           valid;
  logic           ready;
  logic [E_W-1:0] composite_energy;
  logic [M_W-1:0] composite_magnitude;
  logic           edge_flag;
  logic           frame_end;
  modport source(output valid, composite_energy, composite_magnitude, edge_flag, frame_end,
                 input ready);
  modport sink(input valid, composite_energy, composite_magnitude, edge_flag, frame_end,
               output ready);
endinterface

>>> src/cge_ctrl.sv
// raster counters, border decisions and sequencing of one word
module cge_ctrl #(
  parameter int MAX_WIDTH = cge_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_padding,
  output logic                         in_ready,
  input  cge_pkg::cfg_t                cfg,
  input  cge_pkg::stat_t               stat,
  output cge_pkg::cmd_t                cmd,
  output logic [$clog2(MAX_WIDTH)-1:0] addr
);
  import cge_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MEM_RD, S_SHIFT, S_PICK, S_DIFF, S_SQUARE, S_SUM,
    S_WEIGHT, S_TOTAL, S_ROOT_GO, S_ROOT, S_OUT
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   col_r;
  logic [ROW_W-1:0] row_r;
  logic [AW-1:0]   addr_r;
  logic            emit_a_r, emit_b_r;
  logic            kc2_r, hl_r, hr_r, hu_r, hd_r, fend_r;

  logic [GEOM_W-1:0] w, col_ext, c1_ext, c_ext;
  logic [ROW_W-1:0]  h, r, h1;
  logic [CW-1:0]     c, c1;
  logic              acc, wrap, is_final, flush, ign, emit_a, emit_b;
  logic              kc2_nxt, hl_nxt, hr_nxt, hu_nxt, hd_nxt, fend_nxt;
  logic [CW-1:0]     col_nxt;
  logic [ROW_W-1:0]  row_nxt;

  always_comb begin
    if (cfg.width == '0) w = GEOM_W'(1);
    else if (GEOM_W'(cfg.width) > GEOM_W'(MAX_WIDTH)) w = GEOM_W'(MAX_WIDTH);
    else w = GEOM_W'(cfg.width);
    h  = (cfg.height == '0) ? ROW_W'(1) : ROW_W'(cfg.height);
    h1 = h + ROW_W'(1);
    col_ext = GEOM_W'(col_r);
    wrap = col_ext >= w;
    c = wrap ? '0 : col_r;
    r = wrap ? row_r + ROW_W'(1) : row_r;
    c_ext = GEOM_W'(c);
    is_final = r >= h1;
    flush = r >= h;
    ign = !is_final && !flush && in_padding;
    emit_a = !is_final && !ign && (c == '0) && (r >= ROW_W'(2));
    emit_b = !is_final && !ign && (c != '0) && (r != '0);
    c1 = c + CW'(1);
    c1_ext = GEOM_W'(c1);
    if (is_final) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (ign) begin
      col_nxt = c;
      row_nxt = r;
    end else if (c1_ext >= w) begin
      col_nxt = '0;
      row_nxt = r + ROW_W'(1);
    end else begin
      col_nxt = c1;
      row_nxt = r;
    end
    if (is_final || emit_a) begin
      kc2_nxt  = 1'b1;
      hl_nxt   = w > GEOM_W'(1);
      hr_nxt   = 1'b0;
      hu_nxt   = r > ROW_W'(2);
      hd_nxt   = !is_final && (r < h1);
      fend_nxt = is_final;
    end else begin
      kc2_nxt  = 1'b0;
      hl_nxt   = c_ext > GEOM_W'(1);
      hr_nxt   = 1'b1;
      hu_nxt   = r > ROW_W'(1);
      hd_nxt   = r < h;
      fend_nxt = 1'b0;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign addr     = addr_r;

  always_comb begin
    cmd            = '0;
    cmd.take       = acc;
    cmd.zero_pix   = flush;
    cmd.mem_rd     = (state_r == S_MEM_RD);
    cmd.shift      = (state_r == S_SHIFT);
    cmd.pick       = ((state_r == S_MEM_RD) && emit_a_r) || (state_r == S_PICK);
    cmd.kc2        = kc2_r;
    cmd.hl         = hl_r;
    cmd.hr         = hr_r;
    cmd.hu         = hu_r;
    cmd.hd         = hd_r;
    cmd.fend       = fend_r;
    cmd.sqrt_start = (state_r == S_ROOT_GO);
    cmd.load_out   = (state_r == S_OUT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      emit_a_r <= 1'b0;
      emit_b_r <= 1'b0;
      kc2_r    <= 1'b0;
      hl_r     <= 1'b0;
      hr_r     <= 1'b0;
      hu_r     <= 1'b0;
      hd_r     <= 1'b0;
      fend_r   <= 1'b0;
      addr_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            col_r    <= col_nxt;
            row_r    <= row_nxt;
            addr_r   <= c[AW-1:0];
            emit_a_r <= emit_a;
            emit_b_r <= emit_b;
            kc2_r    <= kc2_nxt;
            hl_r     <= hl_nxt;
            hr_r     <= hr_nxt;
            hu_r     <= hu_nxt;
            hd_r     <= hd_nxt;
            fend_r   <= fend_nxt;
            priority if (is_final) state_r <= S_PICK;
            else if (ign) state_r <= S_IDLE;
            else state_r <= S_MEM_RD;
          end
        end
        S_MEM_RD: state_r <= S_SHIFT;
        S_SHIFT: begin
          priority if (emit_b_r) state_r <= S_PICK;
          else if (emit_a_r) state_r <= S_DIFF;
          else state_r <= S_IDLE;
        end
        S_PICK:    state_r <= S_DIFF;
        S_DIFF:    state_r <= S_SQUARE;
        S_SQUARE:  state_r <= S_SUM;
        S_SUM:     state_r <= S_WEIGHT;
        S_WEIGHT:  state_r <= S_TOTAL;
        S_TOTAL:   state_r <= S_ROOT_GO;
        S_ROOT_GO: state_r <= S_ROOT;
        S_ROOT:    if (stat.sqrt_done) state_r <= S_OUT;
        S_OUT:     if (stat.out_free) state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !ign |=> !in_ready)
    else $error("new word taken while previous word in flight");
  a_load_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.sqrt_done)
    else $error("result loaded before square root finished");
  a_root_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_start |=> !stat.sqrt_done)
    else $error("square root did not start");
`endif
endmodule

>>> src/cge_dp.sv
// line stores, 3x3 window, gradient arithmetic, square root and result register
module cge_dp #(
  parameter int MAX_WIDTH = cge_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cge_pkg::cmd_t                cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  cge_pkg::cfg_t                cfg,
  input  logic [cge_pkg::CH_W-1:0]     in_red,
  input  logic [cge_pkg::CH_W-1:0]     in_green,
  input  logic [cge_pkg::CH_W-1:0]     in_blue,
  output cge_pkg::stat_t               stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cge_pkg::E_W-1:0]      out_energy,
  output logic [cge_pkg::M_W-1:0]      out_mag,
  output logic                         out_edge,
  output logic                         out_fend
);
  import cge_pkg::*;

  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] up_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_r, mid_rd_r;
  logic [PIX_W-1:0] win_r [9];
  logic [PIX_W-1:0] pr_r, pl_r, pd_r, pu_r;
  logic [PIX_W-1:0] cen, lft, rgt, upp, dwn;

  logic signed [8:0] d9 [8];
  logic signed [9:0] d10 [6];
  logic signed [8:0] d9_r [8];
  logic signed [9:0] d10_r [6];
  logic [15:0] sq9_r [8];
  logic [17:0] sq10_r [6];
  logic [18:0] gc_r, gc2_r;
  logic [16:0] gd_r;
  logic [20:0] gk_r;
  logic [20:0] wd_r;
  logic [E_W-1:0] wk_r, e_r;
  logic [E_W-1:0] rem_r, root_r, bit_r;
  logic [E_W:0]   trial;
  logic           out_valid_r, fend_r, edge_r;
  logic [E_W-1:0] energy_r;
  logic [M_W-1:0] mag_r;

  always_ff @(posedge clk) begin
    if (cmd.take) pix_r <= cmd.zero_pix ? '0 : {in_red, in_green, in_blue};
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      up_rd_r  <= up_mem[addr];
      mid_rd_r <= mid_mem[addr];
    end
    if (cmd.shift) begin
      up_mem[addr]  <= mid_rd_r;
      mid_mem[addr] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cmd.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= up_rd_r;
      win_r[5] <= mid_rd_r;
      win_r[8] <= pix_r;
    end
  end

  // border replication picks the centre for a missing neighbour
  always_comb begin
    cen = cmd.kc2 ? win_r[5] : win_r[4];
    lft = cmd.kc2 ? win_r[4] : win_r[3];
    rgt = cmd.kc2 ? win_r[6] : win_r[5];
    upp = cmd.kc2 ? win_r[2] : win_r[1];
    dwn = cmd.kc2 ? win_r[8] : win_r[7];
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      pr_r <= cmd.hr ? rgt : cen;
      pl_r <= cmd.hl ? lft : cen;
      pd_r <= cmd.hd ? dwn : cen;
      pu_r <= cmd.hu ? upp : cen;
    end
  end

  always_comb begin
    logic [PIX_W-1:0] a, b;
    for (int p = 0; p < 2; p++) begin
      a = (p == 0) ? pr_r : pd_r;
      b = (p == 0) ? pl_r : pu_r;
      d9[p*4]   = $signed({1'b0, a[23:16]}) - $signed({1'b0, b[23:16]});
      d9[p*4+1] = $signed({1'b0, a[15:8]}) - $signed({1'b0, b[15:8]});
      d9[p*4+2] = $signed({1'b0, a[7:0]}) - $signed({1'b0, b[7:0]});
      d9[p*4+3] = $signed({1'b0, spread8(a)}) - $signed({1'b0, spread8(b)});
      d10[p*3]   = 10'(d9[p*4]) - 10'(d9[p*4+1]);
      d10[p*3+1] = 10'(d9[p*4]) - 10'(d9[p*4+2]);
      d10[p*3+2] = 10'(d9[p*4+1]) - 10'(d9[p*4+2]);
    end
  end

  always_ff @(posedge clk) begin
    logic signed [17:0] p9;
    logic signed [19:0] p10;
    for (int i = 0; i < 8; i++) d9_r[i] <= d9[i];
    for (int i = 0; i < 6; i++) d10_r[i] <= d10[i];
    for (int i = 0; i < 8; i++) begin
      p9 = 18'(d9_r[i]) * 18'(d9_r[i]);
      sq9_r[i] <= p9[15:0];
    end
    for (int i = 0; i < 6; i++) begin
      p10 = 20'(d10_r[i]) * 20'(d10_r[i]);
      sq10_r[i] <= p10[17:0];
    end
    gc_r  <= 19'(sq9_r[0]) + 19'(sq9_r[1]) + 19'(sq9_r[2])
           + 19'(sq9_r[4]) + 19'(sq9_r[5]) + 19'(sq9_r[6]);
    gd_r  <= 17'(sq9_r[3]) + 17'(sq9_r[7]);
    gk_r  <= 21'(sq10_r[0]) + 21'(sq10_r[1]) + 21'(sq10_r[2])
           + 21'(sq10_r[3]) + 21'(sq10_r[4]) + 21'(sq10_r[5]);
    gc2_r <= gc_r;
    wd_r  <= 21'(cfg.delta_wt) * 21'(gd_r);
    wk_r  <= E_W'(cfg.chan_wt) * E_W'(gk_r);
    e_r   <= E_W'(gc2_r) + E_W'(wd_r) + wk_r;
  end

  // restoring square root, a result bit per step
  assign trial = (E_W+1)'(root_r) + (E_W+1)'(bit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (cmd.sqrt_start) begin
      rem_r  <= e_r;
      root_r <= '0;
      bit_r  <= E_W'(1) << (E_W - 1);
    end else if (bit_r != '0) begin
      if ((E_W+1)'(rem_r) >= trial) begin
        rem_r  <= rem_r - trial[E_W-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign stat.sqrt_done = (bit_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      energy_r <= e_r;
      mag_r    <= root_r[M_W-1:0];
      edge_r   <= root_r[M_W-1:0] >= cfg.thr;
      fend_r   <= cmd.fend;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_energy = energy_r;
  assign out_mag    = mag_r;
  assign out_edge   = edge_r;
  assign out_fend   = fend_r;

`ifndef SYNTHESIS
  a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (27'(out_mag) * 27'(out_mag)) <= 27'(out_energy))
    else $error("magnitude above square root of energy");
  a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> ((27'(out_mag) + 27'(1)) * (27'(out_mag) + 27'(1))) > 27'(out_energy))
    else $error("magnitude below floor square root of energy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy) && $stable(out_fend))
    else $error("result word changed while waiting");
`endif
endmodule

>>> src/color_gradient_edge_map.sv
// top level of the color gradient edge map
//
//  channel | dir | handshake       | word
//  in_ch   | in  | valid / ready   | red, green, blue, padding
//  out_ch  | out | valid / ready   | composite_energy, composite_magnitude, edge_flag, frame_end
//  cfg_*   | in  | cfg_we only     | cfg_index, cfg_data
//
//  one word at a time: an ignored padding word stays in S_IDLE, a word with no result does the
//  line store read and write in S_MEM_RD and S_SHIFT, a word with a result adds 5 arithmetic
//  stages, 13 square root steps of the root unit and the result load
//  the next word is taken while a finished result waits in the output register
//  synchronous active-low reset; line stores are not cleared, no clearing pass
module color_gradient_edge_map #(
  parameter int MAX_WIDTH = cge_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cge_in_if.sink                         in_ch,
  cge_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cge_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cge_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cge_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;
  logic [$clog2(MAX_WIDTH)-1:0] addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width    <= RST_WIDTH;
      cfg_r.height   <= RST_HEIGHT;
      cfg_r.delta_wt <= RST_DELTA;
      cfg_r.chan_wt  <= RST_CHAN;
      cfg_r.thr      <= RST_THR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_r.width    <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_r.height   <= cfg_data[HEIGHT_W-1:0];
        CFG_DELTA_WT:     cfg_r.delta_wt <= cfg_data[WT_W-1:0];
        CFG_CHAN_WT:      cfg_r.chan_wt  <= cfg_data[WT_W-1:0];
        CFG_EDGE_THR:     cfg_r.thr      <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  cge_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_padding (in_ch.padding),
    .in_ready   (in_ch.ready),
    .cfg        (cfg_r),
    .stat       (stat),
    .cmd        (cmd),
    .addr       (addr)
  );

  cge_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .addr       (addr),
    .cfg        (cfg_r),
    .in_red     (in_ch.red),
    .in_green   (in_ch.green),
    .in_blue    (in_ch.blue),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_energy (out_ch.composite_energy),
    .out_mag    (out_ch.composite_magnitude),
    .out_edge   (out_ch.edge_flag),
    .out_fend   (out_ch.frame_end)
  );
endmodule
